// ----- src/arsg_pkg.sv -----
// Package with shared types, constants and command structures for the audio ring store.
package arsg_pkg;

  localparam int unsigned Frames     = 4096;
  localparam int unsigned Channels   = 2;
  localparam int unsigned StoreSize  = Frames * Channels;
  localparam int unsigned AddrW      = $clog2(StoreSize);
  localparam int unsigned FrameW     = $clog2(Frames);
  localparam int unsigned ChanCntW   = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int unsigned GainW      = 40;
  localparam int unsigned QuoW       = 32;
  localparam int unsigned PeakW      = 26;
  localparam logic [PeakW-1:0] PeakNum = PeakW'(1024 * 32768);

  localparam logic [2:0] OpWrite = 3'd0;
  localparam logic [2:0] OpRead  = 3'd1;
  localparam logic [2:0] OpRamp  = 3'd2;
  localparam logic [2:0] OpRampS = 3'd3;
  localparam logic [2:0] OpPeak  = 3'd4;

  typedef enum logic [3:0] {
    CmdNone,
    CmdClear,
    CmdLoad,
    CmdWrite,
    CmdRead,
    CmdRampBegin,
    CmdDivStep,
    CmdRampRead,
    CmdRampApply,
    CmdPeakRead,
    CmdPeakNext,
    CmdPeakDivInit,
    CmdPeakDivStep,
    CmdFinish
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic scan_done;
    logic peak_zero;
  } stat_t;

endpackage

// ----- src/audio_ring_store_gain_ramp.sv -----
// Top level of the circular audio store with gain-ramped read-out and peak measurement.
//
//   Channel | Handshake                | Payload
//   input   | in_valid_i / in_ready_o  | operation_i .. peak_count_i
//   output  | out_valid_o / out_ready_i| sample_out_o, peak_gain_o, ramp_error_o
//
// Write and read pass through their own state and then the done state; a ramp sample passes
// through the registered memory read and then the multiply and saturate step.
// Ramp begin runs the one-bit-per-cycle 32-bit divider to find the gain step.
// Peak measure does one memory read per sample over peak_count+1 samples, then the
// divider; when every scanned sample is zero the divider is skipped.
// After reset the store is cleared one entry per cycle, all 8192 entries; no transfer is accepted
// until that pass ends.
// A new input transfer is taken only when the controller is idle and the result register is
// empty or being emptied in the same cycle.
module audio_ring_store_gain_ramp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 operation_i,
  input  logic [15:0]                frame_index_i,
  input  logic [2:0]                 channel_i,
  input  logic signed [15:0]         sample_in_i,
  input  logic signed [15:0]         gain_start_i,
  input  logic signed [15:0]         gain_end_i,
  input  logic [15:0]                ramp_length_i,
  input  logic [15:0]                peak_count_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [15:0]         sample_out_o,
  output logic [arsg_pkg::PeakW-1:0] peak_gain_o,
  output logic                       ramp_error_o
);

  arsg_pkg::ctrl_t ctrl;
  arsg_pkg::stat_t stat;

  // The controller decides the sequence of commands for each operation.
  arsg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .operation_i (operation_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // The datapath holds the store, the ramp state and the result registers.
  arsg_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .frame_index_i (frame_index_i),
    .channel_i     (channel_i),
    .sample_in_i   (sample_in_i),
    .gain_start_i  (gain_start_i),
    .gain_end_i    (gain_end_i),
    .ramp_length_i (ramp_length_i),
    .peak_count_i  (peak_count_i),
    .sample_out_o  (sample_out_o),
    .peak_gain_o   (peak_gain_o),
    .ramp_error_o  (ramp_error_o)
  );

endmodule

// ----- src/arsg_datapath.sv -----
// Datapath of the audio ring store: sample memory, ramp state, multiplier and serial divider.
module arsg_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  arsg_pkg::ctrl_t               ctrl_i,
  output arsg_pkg::stat_t               stat_o,
  input  logic [15:0]                   frame_index_i,
  input  logic [2:0]                    channel_i,
  input  logic signed [15:0]            sample_in_i,
  input  logic signed [15:0]            gain_start_i,
  input  logic signed [15:0]            gain_end_i,
  input  logic [15:0]                   ramp_length_i,
  input  logic [15:0]                   peak_count_i,
  output logic signed [15:0]            sample_out_o,
  output logic [arsg_pkg::PeakW-1:0]    peak_gain_o,
  output logic                          ramp_error_o
);

  localparam int unsigned AW = arsg_pkg::AddrW;
  localparam int unsigned GW = arsg_pkg::GainW;
  localparam int unsigned QW = arsg_pkg::QuoW;
  localparam int unsigned PW = arsg_pkg::PeakW;

  logic signed [15:0] mem_q [arsg_pkg::StoreSize];
  logic signed [15:0] rdata_q;

  logic [15:0] frame_q;
  logic [2:0]  chan_q;
  logic signed [15:0] smp_q, gs_q, ge_q;
  logic [15:0] len_q;

  logic [AW-1:0] ptr_q, scan_q, clr_q;
  logic [arsg_pkg::ChanCntW-1:0] ccnt_q;
  logic signed [GW-1:0] gain_q, step_q;
  logic [16:0] left_q;
  logic [15:0] peak_q;

  // Shared restoring divider: unsigned magnitude numerator over 16-bit divisor.
  logic [QW-1:0] num_q, quo_q;
  logic [16:0]   rem_q;
  logic [15:0]   den_q;
  logic [5:0]    cnt_q;
  logic          neg_q;

  logic signed [15:0] res_q;
  logic [PW-1:0]      pg_q;
  logic               err_q;

  logic [AW-1:0] base;
  logic [AW-1:0] in_base;
  logic          chan_ok;
  logic [AW-1:0] waddr, raddr;
  logic          we;
  logic signed [15:0] wdata;
  logic [16:0]   rem_sh;
  logic signed [23:0] g_int;
  logic signed [39:0] prod;
  logic signed [29:0] scaled;
  logic signed [GW:0] gsum;
  logic signed [16:0] diff;
  logic [15:0]   mag;

  assign base    = AW'(32'(frame_q[arsg_pkg::FrameW-1:0]) * arsg_pkg::Channels);
  assign in_base = AW'(32'(frame_index_i[arsg_pkg::FrameW-1:0]) * arsg_pkg::Channels);
  assign chan_ok = 32'(chan_q) < arsg_pkg::Channels;
  assign rem_sh  = {rem_q[15:0], num_q[QW-1]};
  assign g_int   = gain_q[GW-1:16];
  assign prod    = 40'(rdata_q) * 40'(g_int);
  assign scaled  = prod[39:10];
  assign gsum    = {gain_q[GW-1], gain_q} + {step_q[GW-1], step_q};
  assign diff    = 17'(ge_q) - 17'(gs_q);
  assign mag     = rdata_q[15] ? 16'(-17'(rdata_q)) : 16'(rdata_q);

  always_comb begin
    we    = 1'b0;
    waddr = clr_q;
    wdata = '0;
    raddr = base + AW'(chan_q);
    case (ctrl_i.cmd)
      arsg_pkg::CmdClear: we = 1'b1;
      // A read fetches its sample as the transfer is taken, so the data is ready next cycle.
      arsg_pkg::CmdLoad: raddr = in_base + AW'(channel_i);
      arsg_pkg::CmdWrite: begin
        we    = chan_ok;
        waddr = base + AW'(chan_q);
        wdata = smp_q;
      end
      arsg_pkg::CmdRampRead: raddr = ptr_q;
      arsg_pkg::CmdPeakRead: raddr = scan_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmd == arsg_pkg::CmdLoad) begin
      frame_q <= frame_index_i;
      chan_q  <= channel_i;
      smp_q   <= sample_in_i;
      gs_q    <= gain_start_i;
      ge_q    <= gain_end_i;
      len_q   <= ramp_length_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      ccnt_q <= '0;
      gain_q <= '0;
      step_q <= '0;
      clr_q  <= '0;
      scan_q <= '0;
      left_q <= '0;
      peak_q <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      res_q  <= '0;
      pg_q   <= '0;
      err_q  <= 1'b0;
    end else begin
      case (ctrl_i.cmd)
        arsg_pkg::CmdClear: clr_q <= clr_q + AW'(1);
        arsg_pkg::CmdLoad: begin
          res_q <= '0;
          pg_q  <= '0;
          err_q <= 1'b0;
        end
        arsg_pkg::CmdRead: begin
          if (chan_ok) begin
            res_q <= rdata_q;
          end
        end
        arsg_pkg::CmdRampBegin: begin
          ptr_q  <= base;
          ccnt_q <= '0;
          gain_q <= GW'(gs_q) <<< 16;
          step_q <= '0;
          err_q  <= (len_q == '0);
          neg_q  <= diff[16];
          num_q  <= QW'(diff[16] ? -diff : diff) << 16;
          den_q  <= len_q;
          rem_q  <= '0;
          quo_q  <= '0;
          cnt_q  <= 6'(QW);
        end
        arsg_pkg::CmdDivStep, arsg_pkg::CmdPeakDivStep: begin
          num_q <= num_q << 1;
          cnt_q <= cnt_q - 6'd1;
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sh - {1'b0, den_q};
            quo_q <= {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[QW-2:0], 1'b0};
          end
          if (cnt_q == 6'd1) begin
            if (ctrl_i.cmd == arsg_pkg::CmdDivStep) begin
              if (den_q != '0) begin
                step_q <= neg_q ? -GW'({quo_q[QW-2:0], rem_sh >= {1'b0, den_q}})
                                :  GW'({quo_q[QW-2:0], rem_sh >= {1'b0, den_q}});
              end
            end else begin
              pg_q <= PW'({quo_q[QW-2:0], rem_sh >= {1'b0, den_q}});
            end
          end
        end
        arsg_pkg::CmdRampApply: begin
          if (scaled > 30'sd32767) begin
            res_q <= 16'sd32767;
          end else if (scaled < -30'sd32768) begin
            res_q <= -16'sd32768;
          end else begin
            res_q <= scaled[15:0];
          end
          ptr_q <= (32'(ptr_q) == arsg_pkg::StoreSize - 1) ? '0 : ptr_q + AW'(1);
          if (32'(ccnt_q) == arsg_pkg::Channels - 1) begin
            ccnt_q <= '0;
            if (gsum[GW] != gsum[GW-1]) begin
              gain_q <= gsum[GW] ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
            end else begin
              gain_q <= gsum[GW-1:0];
            end
          end else begin
            ccnt_q <= ccnt_q + 1'b1;
          end
        end
        arsg_pkg::CmdPeakDivInit: begin
          num_q <= QW'(arsg_pkg::PeakNum);
          den_q <= peak_q;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= 6'(QW);
        end
        default: ;
      endcase
      // Peak scan bookkeeping: start on load, fold in each read sample.
      if (ctrl_i.cmd == arsg_pkg::CmdLoad) begin
        scan_q <= in_base;
        left_q <= {1'b0, peak_count_i} + 17'd1;
        peak_q <= '0;
      end else if (ctrl_i.cmd == arsg_pkg::CmdPeakRead) begin
        scan_q <= (32'(scan_q) == arsg_pkg::StoreSize - 1) ? '0 : scan_q + AW'(1);
        left_q <= left_q - 17'd1;
      end else if (ctrl_i.cmd == arsg_pkg::CmdPeakNext) begin
        if (mag > peak_q) begin
          peak_q <= mag;
        end
      end
    end
  end

  assign stat_o.clear_done = (32'(clr_q) == arsg_pkg::StoreSize - 1);
  assign stat_o.div_done   = (cnt_q == 6'd1);
  assign stat_o.scan_done  = (left_q == 17'd0);
  assign stat_o.peak_zero  = (peak_q == '0);

  assign sample_out_o = res_q;
  assign peak_gain_o  = pg_q;
  assign ramp_error_o = err_q;

endmodule

// ----- src/arsg_ctrl.sv -----
// Controller state machine that sequences each operation through the datapath.
module arsg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  logic [2:0]      operation_i,
  input  arsg_pkg::stat_t stat_i,
  output arsg_pkg::ctrl_t ctrl_o
);

  typedef enum logic [3:0] {
    StClear, StIdle, StWrite, StRead, StRampBegin, StDiv, StRampRead,
    StRampApply, StPeakRead, StPeakNext, StPeakDivInit, StPeakDiv, StDone
  } state_e;

  state_e state_q;
  logic out_valid_q;

  // The result register parts the sides: a new item can load once the old result leaves.
  assign in_ready_o  = (state_q == StIdle) && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    ctrl_o.cmd = arsg_pkg::CmdNone;
    case (state_q)
      StClear:       ctrl_o.cmd = arsg_pkg::CmdClear;
      StIdle:        ctrl_o.cmd = (in_valid_i && in_ready_o) ? arsg_pkg::CmdLoad
                                                              : arsg_pkg::CmdNone;
      StWrite:       ctrl_o.cmd = arsg_pkg::CmdWrite;
      StRead:        ctrl_o.cmd = arsg_pkg::CmdRead;
      StRampBegin:   ctrl_o.cmd = arsg_pkg::CmdRampBegin;
      StDiv:         ctrl_o.cmd = arsg_pkg::CmdDivStep;
      StRampRead:    ctrl_o.cmd = arsg_pkg::CmdRampRead;
      StRampApply:   ctrl_o.cmd = arsg_pkg::CmdRampApply;
      StPeakRead:    ctrl_o.cmd = arsg_pkg::CmdPeakRead;
      StPeakNext:    ctrl_o.cmd = arsg_pkg::CmdPeakNext;
      StPeakDivInit: ctrl_o.cmd = arsg_pkg::CmdPeakDivInit;
      StPeakDiv:     ctrl_o.cmd = arsg_pkg::CmdPeakDivStep;
      default:       ctrl_o.cmd = arsg_pkg::CmdNone;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          if (stat_i.clear_done) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i && in_ready_o) begin
            case (operation_i)
              arsg_pkg::OpWrite: state_q <= StWrite;
              arsg_pkg::OpRead:  state_q <= StRead;
              arsg_pkg::OpRamp:  state_q <= StRampBegin;
              arsg_pkg::OpRampS: state_q <= StRampRead;
              arsg_pkg::OpPeak:  state_q <= StPeakRead;
              default:           state_q <= StDone;
            endcase
          end
        end
        StWrite:       state_q <= StDone;
        StRead:        state_q <= StDone;
        StRampBegin:   state_q <= StDiv;
        StDiv:         state_q <= stat_i.div_done ? StDone : StDiv;
        StRampRead:    state_q <= StRampApply;
        StRampApply:   state_q <= StDone;
        StPeakRead:    state_q <= StPeakNext;
        StPeakNext:    state_q <= stat_i.scan_done ? StPeakDivInit : StPeakRead;
        StPeakDivInit: state_q <= stat_i.peak_zero ? StDone : StPeakDiv;
        StPeakDiv:     state_q <= stat_i.div_done ? StDone : StPeakDiv;
        StDone: begin
          out_valid_q <= 1'b1;
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ----- sim/tb_audio_ring_store_gain_ramp.sv -----
// Self-checking testbench for the audio ring store with gain ramp and peak measurement.
module tb_audio_ring_store_gain_ramp;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 400000;
  localparam longint GainHi = 64'sd549755813887;
  localparam longint GainLo = -64'sd549755813888;

  typedef struct packed {
    logic signed [15:0]         sample;
    logic [arsg_pkg::PeakW-1:0] peak;
    logic                       err;
  } audio_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] operation_i = '0;
  logic [15:0] frame_index_i = '0;
  logic [2:0] channel_i = '0;
  logic signed [15:0] sample_in_i = '0;
  logic signed [15:0] gain_start_i = '0;
  logic signed [15:0] gain_end_i = '0;
  logic [15:0] ramp_length_i = '0;
  logic [15:0] peak_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [15:0] sample_out_o;
  logic [arsg_pkg::PeakW-1:0] peak_gain_o;
  logic ramp_error_o;

  // Shadow copy of the block's state, advanced once per accepted transfer.
  logic signed [15:0] shadow_store [arsg_pkg::StoreSize];
  int unsigned shadow_ptr;
  int unsigned shadow_chan_cnt;
  longint shadow_gain;
  longint shadow_step;

  audio_result_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  audio_ring_store_gain_ramp u_top (.*);

  // Floor division by a power of two; >>> on a signed longint does this.
  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic audio_result_t predict_audio(logic [2:0] op, logic [15:0] frame,
      logic [2:0] chan, logic signed [15:0] smp, logic signed [15:0] g0,
      logic signed [15:0] g1, logic [15:0] len, logic [15:0] cnt);
    audio_result_t r;
    int unsigned base;
    int unsigned p;
    int unsigned peak;
    int unsigned mag;
    longint g;
    longint v;
    r = '0;
    base = (frame % arsg_pkg::Frames) * arsg_pkg::Channels;
    case (op)
      arsg_pkg::OpWrite: if (chan < arsg_pkg::Channels) shadow_store[base + chan] = smp;
      arsg_pkg::OpRead: if (chan < arsg_pkg::Channels) r.sample = shadow_store[base + chan];
      arsg_pkg::OpRamp: begin
        shadow_ptr = base;
        shadow_chan_cnt = 0;
        shadow_gain = longint'(g0) * 65536;
        if (len == 0) begin
          shadow_step = 0;
          r.err = 1'b1;
        end else begin
          shadow_step = ((longint'(g1) - longint'(g0)) * 65536) / longint'(len);
        end
      end
      arsg_pkg::OpRampS: begin
        p = (shadow_ptr < arsg_pkg::StoreSize) ? shadow_ptr : 0;
        g = floor_shr(shadow_gain, 16);
        v = floor_shr(longint'(shadow_store[p]) * g, 10);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        r.sample = 16'(v);
        shadow_ptr = (p + 1 >= arsg_pkg::StoreSize) ? 0 : p + 1;
        shadow_chan_cnt++;
        if (shadow_chan_cnt >= arsg_pkg::Channels) begin
          shadow_chan_cnt = 0;
          shadow_gain = shadow_gain + shadow_step;
          if (shadow_gain > GainHi) shadow_gain = GainHi;
          if (shadow_gain < GainLo) shadow_gain = GainLo;
        end
      end
      arsg_pkg::OpPeak: begin
        p = base;
        peak = 0;
        for (int i = 0; i <= int'(cnt); i++) begin
          mag = (shadow_store[p] < 0) ? -int'(shadow_store[p]) : int'(shadow_store[p]);
          if (mag > peak) peak = mag;
          p = (p + 1 >= arsg_pkg::StoreSize) ? 0 : p + 1;
        end
        if (peak != 0) r.peak = arsg_pkg::PeakW'((1024 * 32768) / peak);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one transfer, wait for acceptance, and queue its expected result.
  task automatic send_audio(logic [2:0] op, logic [15:0] frame = 0, logic [2:0] chan = 0,
      logic signed [15:0] smp = 0, logic signed [15:0] g0 = 0, logic signed [15:0] g1 = 0,
      logic [15:0] len = 0, logic [15:0] cnt = 0);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = op;
    frame_index_i = frame;
    channel_i = chan;
    sample_in_i = smp;
    gain_start_i = g0;
    gain_end_i = g1;
    ramp_length_i = len;
    peak_count_i = cnt;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_results.push_back(predict_audio(op, frame, chan, smp, g0, g1, len, cnt));
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver side: random stalls, sampled on the rising edge.
  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    audio_result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (sample_out_o !== exp_r.sample) begin
          $error("sample_out expected %0d actual %0d", exp_r.sample, sample_out_o);
          error_count++;
        end
        if (peak_gain_o !== exp_r.peak) begin
          $error("peak_gain expected %0d actual %0d", exp_r.peak, peak_gain_o);
          error_count++;
        end
        if (ramp_error_o !== exp_r.err) begin
          $error("ramp_error expected %0b actual %0b", exp_r.err, ramp_error_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer; covers the clearing pass after reset too.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_idling(int unsigned snd, int unsigned rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  // Extremes of every field, each operation, the special cases and unused codes.
  task automatic test_directed();
    send_audio(arsg_pkg::OpRead, 16'd0, 3'd0);
    send_audio(arsg_pkg::OpRampS);
    send_audio(arsg_pkg::OpPeak, 16'd0, 0, 0, 0, 0, 0, 16'd0);
    send_audio(arsg_pkg::OpWrite, 16'd4095, 3'd1, -16'sd32768);
    send_audio(arsg_pkg::OpWrite, 16'd4096, 3'd0, 16'sd32767);
    send_audio(arsg_pkg::OpWrite, 16'hFFFF, 3'd0, -16'sd1);
    send_audio(arsg_pkg::OpWrite, 16'd5, 3'd7, 16'sd1234);
    send_audio(arsg_pkg::OpRead, 16'd5, 3'd7);
    send_audio(arsg_pkg::OpRead, 16'hFFFF, 3'd1);
    send_audio(arsg_pkg::OpRead, 16'd4096, 3'd0);
    send_audio(3'd5, 16'hFFFF, 3'd7, -16'sd1, -16'sd1, -16'sd1, 16'hFFFF, 16'hFFFF);
    send_audio(3'd6);
    send_audio(3'd7);
    // Zero length ramp starts with a flat gain and flags an error.
    send_audio(arsg_pkg::OpRamp, 16'd4095, 0, 0, 16'sd32767, -16'sd32768, 16'd0);
    repeat (4) send_audio(arsg_pkg::OpRampS);
    // Full swing ramp over one frame, wrapping the pointer at the end of the store.
    send_audio(arsg_pkg::OpRamp, 16'd4095, 0, 0, -16'sd32768, 16'sd32767, 16'd1);
    repeat (4) send_audio(arsg_pkg::OpRampS);
    send_audio(arsg_pkg::OpRamp, 16'd0, 0, 0, 16'sd1024, 16'sd0, 16'hFFFF);
    // Peak scans, the first one wrapping around the store.
    send_audio(arsg_pkg::OpPeak, 16'd4095, 0, 0, 0, 0, 0, 16'd5);
    send_audio(arsg_pkg::OpPeak, 16'd10, 0, 0, 0, 0, 0, 16'd3);
  endtask

  // Random mix of writes, reads, ramps followed by runs of ramp samples, lone ramp samples, peaks and noise.
  task automatic test_random(int unsigned n_items);
    logic [15:0] f;
    int unsigned k;
    k = 0;
    while (k < n_items) begin
      f = 16'($urandom);
      case ($urandom_range(9))
        0, 1, 2: send_audio(arsg_pkg::OpWrite,
                            ($urandom_range(3) == 0) ? f : 16'($urandom_range(31)),
                            3'($urandom), 16'($urandom));
        3: send_audio(arsg_pkg::OpRead, ($urandom_range(1) == 0) ? f : 16'($urandom_range(31)),
                      3'($urandom));
        4, 5: begin
          send_audio(arsg_pkg::OpRamp, ($urandom_range(3) == 0) ? f : 16'($urandom_range(31)),
                     0, 0, 16'($urandom), 16'($urandom),
                     ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
          repeat ($urandom_range(12)) begin
            send_audio(arsg_pkg::OpRampS);
            k++;
          end
        end
        6, 7: send_audio(arsg_pkg::OpRampS);
        8: send_audio(arsg_pkg::OpPeak, ($urandom_range(1) == 0) ? f : 16'($urandom_range(40)),
                      0, 0, 0, 0, 0, ($urandom_range(49) == 0) ? 16'($urandom_range(9000))
                                                               : 16'($urandom_range(24)));
        default: send_audio(3'($urandom_range(7)), f, 3'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom_range(16)));
      endcase
      k++;
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  initial begin
    // The block clears its store after reset, so the shadow starts cleared as well.
    foreach (shadow_store[i]) shadow_store[i] = '0;
    shadow_ptr = 0;
    shadow_chan_cnt = 0;
    shadow_gain = 0;
    shadow_step = 0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    set_idling(0, 0);
    test_random(350);
    set_idling(61, 0);
    test_random(350);
    set_idling(0, 61);
    test_random(350);
    set_idling(35, 35);
    test_random(350);
    drain_results();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
